@@ sv/dpr_pkg.sv @@
// Shared types, constants and helpers of the delimited packet receiver.
package dpr_pkg;

  localparam int unsigned MaxBuffer    = 256;
  localparam int unsigned MaxDelimiter = 8;

  localparam int unsigned ByteW     = 8;
  localparam int unsigned CountW    = 9;
  localparam int unsigned ReqW      = 2;
  localparam int unsigned StatusW   = 3;
  localparam int unsigned DelimLenW = 4;
  localparam int unsigned MatchW    = 4;
  localparam int unsigned DelimW    = MaxDelimiter * ByteW;
  localparam int unsigned CfgIdxW   = 1;
  localparam int unsigned CfgDataW  = DelimW;

  localparam logic [DelimW-1:0]    DelimBytesReset = DelimW'(64'h0A0D);
  localparam logic [DelimLenW-1:0] DelimLenReset   = DelimLenW'(2);

  typedef enum logic [ReqW-1:0] {
    REQ_ARM  = 2'd0,
    REQ_BYTE = 2'd1,
    REQ_STOP = 2'd2
  } req_type_t;

  typedef enum logic [StatusW-1:0] {
    ST_OK       = 3'd0,
    ST_STOPPED  = 3'd1,
    ST_DONE     = 3'd2,
    ST_OVERFLOW = 3'd3,
    ST_IGNORED  = 3'd4
  } status_t;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_DELIM_BYTES = 1'b0,
    CFG_DELIM_LEN   = 1'b1
  } cfg_index_t;

  typedef struct packed {
    logic [ReqW-1:0]   req_type;
    logic [ByteW-1:0]  rx_byte;
    logic [CountW-1:0] buffer_capacity;
  } req_t;

  typedef struct packed {
    status_t           status;
    logic [CountW-1:0] packet_length;
    logic              write_enable;
    logic [CountW-1:0] write_index;
    logic [ByteW-1:0]  write_data;
  } res_t;

  // Effective delimiter length: zero counts as one, clipped at the maximum.
  function automatic logic [DelimLenW-1:0] eff_delim_len(input logic [DelimLenW-1:0] raw);
    logic [DelimLenW-1:0] n;
    n = raw;
    if (n == '0) begin
      n = DelimLenW'(1);
    end
    if (n > DelimLenW'(MaxDelimiter)) begin
      n = DelimLenW'(MaxDelimiter);
    end
    return n;
  endfunction

endpackage

@@ sv/dpr_in_if.sv @@
// Request channel of the delimited packet receiver.
interface dpr_in_if import dpr_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ReqW-1:0]   req_type;
  logic [ByteW-1:0]  rx_byte;
  logic [CountW-1:0] buffer_capacity;

  modport source(output valid, req_type, rx_byte, buffer_capacity, input ready);
  modport sink(input valid, req_type, rx_byte, buffer_capacity, output ready);
endinterface

@@ sv/dpr_out_if.sv @@
// Result channel of the delimited packet receiver.
interface dpr_out_if import dpr_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [StatusW-1:0] status;
  logic [CountW-1:0] packet_length;
  logic              write_enable;
  logic [CountW-1:0] write_index;
  logic [ByteW-1:0]  write_data;

  modport source(output valid, status, packet_length, write_enable, write_index, write_data,
                 input ready);
  modport sink(input valid, status, packet_length, write_enable, write_index, write_data,
               output ready);
endinterface

@@ sv/dpr_core.sv @@
// Receiver state, delimiter registers and the per-request decision logic.
module dpr_core import dpr_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data,
  input  logic                step,
  input  req_t                req,
  output res_t                res
);

  logic [DelimW-1:0]    delim_bytes_r, delim_bytes_nxt;
  logic [DelimLenW-1:0] delim_len_r, delim_len_nxt;
  logic                 listening_r, listening_nxt;
  logic [CountW-1:0]    byte_count_r, byte_count_nxt;
  logic [CountW-1:0]    capacity_r, capacity_nxt;
  logic [MatchW-1:0]    match_count_r, match_count_nxt;

  logic [DelimLenW-1:0] len;
  logic [ByteW-1:0]     dbyte;
  logic [ByteW-1:0]     dfirst;
  logic [MatchW-1:0]    match_inc;
  logic [CountW-1:0]    cnt_inc;
  logic                 done;

  always_comb begin
    delim_bytes_nxt = delim_bytes_r;
    delim_len_nxt   = delim_len_r;
    if (cfg_we) begin
      case (cfg_index_t'(cfg_index))
        CFG_DELIM_BYTES: delim_bytes_nxt = cfg_data[DelimW-1:0];
        CFG_DELIM_LEN:   delim_len_nxt   = cfg_data[DelimLenW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    len       = eff_delim_len(delim_len_r);
    dbyte     = delim_bytes_r[{match_count_r[2:0], 3'b000} +: ByteW];
    dfirst    = delim_bytes_r[ByteW-1:0];
    match_inc = match_count_r + MatchW'(1);
    cnt_inc   = byte_count_r + CountW'(1);
    done      = 1'b0;

    listening_nxt   = listening_r;
    byte_count_nxt  = byte_count_r;
    capacity_nxt    = capacity_r;
    match_count_nxt = match_count_r;

    res = '0;
    res.status = ST_OK;

    case (req_type_t'(req.req_type))
      REQ_ARM: begin
        if (req.buffer_capacity == '0) begin
          listening_nxt = 1'b0;
          capacity_nxt  = '0;
          res.status    = ST_STOPPED;
        end else if (!listening_r) begin
          listening_nxt   = 1'b1;
          capacity_nxt    = (req.buffer_capacity > CountW'(MaxBuffer)) ?
                            CountW'(MaxBuffer) : req.buffer_capacity;
          byte_count_nxt  = '0;
          match_count_nxt = '0;
        end
      end
      REQ_STOP: begin
        listening_nxt = 1'b0;
        capacity_nxt  = '0;
        res.status    = ST_STOPPED;
      end
      REQ_BYTE: begin
        if (!listening_r) begin
          res.status = ST_IGNORED;
        end else begin
          res.write_enable = 1'b1;
          res.write_index  = byte_count_r;
          res.write_data   = req.rx_byte;
          if (req.rx_byte == dbyte) begin
            if (match_inc >= len) begin
              res.packet_length = cnt_inc - CountW'(len);
              res.status        = ST_DONE;
              listening_nxt     = 1'b0;
              byte_count_nxt    = '0;
              capacity_nxt      = '0;
              match_count_nxt   = '0;
              done              = 1'b1;
            end else begin
              match_count_nxt = match_inc;
            end
          end else begin
            match_count_nxt = (req.rx_byte == dfirst) ? MatchW'(1) : '0;
          end
          if (!done) begin
            byte_count_nxt = cnt_inc;
            // count past capacity: last byte is still written, then stop
            if (cnt_inc > capacity_r) begin
              listening_nxt = 1'b0;
              res.status    = ST_OVERFLOW;
            end
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delim_bytes_r <= DelimBytesReset;
      delim_len_r   <= DelimLenReset;
      listening_r   <= 1'b0;
      byte_count_r  <= '0;
      capacity_r    <= '0;
      match_count_r <= '0;
    end else begin
      delim_bytes_r <= delim_bytes_nxt;
      delim_len_r   <= delim_len_nxt;
      if (step) begin
        listening_r   <= listening_nxt;
        byte_count_r  <= byte_count_nxt;
        capacity_r    <= capacity_nxt;
        match_count_r <= match_count_nxt;
      end
    end
  end

  // a partial match never reaches the full delimiter width
  a_match_bound: assert property (@(posedge clk) disable iff (!rst_n)
    match_count_r < MatchW'(MaxDelimiter))
    else $error("match count out of range");

  a_count_in_cap: assert property (@(posedge clk) disable iff (!rst_n)
    listening_r |-> (byte_count_r <= capacity_r))
    else $error("byte count beyond capacity while listening");

  a_cap_valid: assert property (@(posedge clk) disable iff (!rst_n)
    listening_r |-> (capacity_r != '0 && capacity_r <= CountW'(MaxBuffer)))
    else $error("bad capacity while listening");

  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (step && res.status == ST_DONE) |=> (!listening_r && byte_count_r == '0))
    else $error("receiver still listening after packet end");

endmodule

@@ sv/delimited_packet_receiver.sv @@
// Top level of the delimited packet receiver: request/result registers around the core.
//
// Usage:
//   in_req  : request channel (valid/ready). req_type selects arm, byte or stop;
//             rx_byte and buffer_capacity carry the operands.
//   out_res : result channel (valid/ready), exactly one result per request:
//             status, packet_length and a buffer write (enable, index, data).
//   cfg_*   : write port. Index 0 loads the packed delimiter bytes, index 1
//             the delimiter length. Write only while no request is in flight.
// Path: a taken request is held in the request register, decided by the core
//   and its result is captured in the result register, which offers it.
// Throughput: one request per cycle while out_res.ready stays high; the receiver
//   state is updated as a request advances, so a following request sees it immediately.
// Reset: no request or result pending, receiver idle, delimiter CR LF.
// Stall: while a result waits and out_res.ready is low the result register holds, the request
//   register takes one more request only if it is empty, then in_req.ready drops.
module delimited_packet_receiver import dpr_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  dpr_in_if.sink              in_req,
  dpr_out_if.source           out_res,
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data
);

  logic in_valid_r, in_valid_nxt;
  req_t in_req_r, in_req_nxt;
  logic out_valid_r, out_valid_nxt;
  res_t out_res_r, out_res_nxt;

  logic advance;
  logic in_fire;
  res_t core_res;

  assign advance = in_valid_r && (!out_valid_r || out_res.ready);
  assign in_req.ready = !in_valid_r || advance;
  assign in_fire = in_req.valid && in_req.ready;

  dpr_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .step      (advance),
    .req       (in_req_r),
    .res       (core_res)
  );

  always_comb begin
    in_valid_nxt = in_fire || (in_valid_r && !advance);
    in_req_nxt   = in_req_r;
    if (in_fire) begin
      in_req_nxt.req_type        = in_req.req_type;
      in_req_nxt.rx_byte         = in_req.rx_byte;
      in_req_nxt.buffer_capacity = in_req.buffer_capacity;
    end
    out_valid_nxt = advance || (out_valid_r && !out_res.ready);
    out_res_nxt   = advance ? core_res : out_res_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    in_req_r  <= in_req_nxt;
    out_res_r <= out_res_nxt;
  end

  assign out_res.valid         = out_valid_r;
  assign out_res.status        = out_res_r.status;
  assign out_res.packet_length = out_res_r.packet_length;
  assign out_res.write_enable  = out_res_r.write_enable;
  assign out_res.write_index   = out_res_r.write_index;
  assign out_res.write_data    = out_res_r.write_data;

endmodule

@@ tb/delimited_packet_receiver_tb.sv @@
// Self-checking testbench of the delimited packet receiver: request stream, tracker, result check.
module delimited_packet_receiver_tb;
  import dpr_pkg::*;

  // request code with no meaning, used to check that it is ignored
  localparam logic [ReqW-1:0] REQ_NONE = 2'd3;
  localparam int unsigned PhaseItems = 225;
  localparam int unsigned NumPhases  = 8;

  // Tracks receiver state and queues the result each request should produce.
  class deframer_tracker;
    logic [DelimW-1:0]    delim_bytes;
    logic [DelimLenW-1:0] delim_len_raw;
    bit                   listening;
    logic [CountW-1:0]    byte_count;
    logic [CountW-1:0]    capacity;
    logic [MatchW-1:0]    match_count;
    res_t                 pending_results[$];
    int unsigned          fail_count;

    function new();
      delim_bytes   = DelimBytesReset;
      delim_len_raw = DelimLenReset;
      listening     = 1'b0;
      byte_count    = '0;
      capacity      = '0;
      match_count   = '0;
      fail_count    = 0;
    endfunction

    function void write_reg(cfg_index_t idx, logic [DelimW-1:0] value);
      if (idx == CFG_DELIM_BYTES) begin
        delim_bytes = value;
      end else begin
        delim_len_raw = value[DelimLenW-1:0];
      end
    endfunction

    function int unsigned active_len();
      int unsigned n;
      n = delim_len_raw;
      if (n == 0) n = 1;
      if (n > MaxDelimiter) n = MaxDelimiter;
      return n;
    endfunction

    function logic [ByteW-1:0] delim_at(int unsigned i);
      return delim_bytes[(i % MaxDelimiter) * ByteW +: ByteW];
    endfunction

    function int unsigned pending();
      return pending_results.size();
    endfunction

    function void stop_listening();
      listening = 1'b0;
      capacity  = '0;
    endfunction

    // Advance the state by one accepted request and queue its result.
    function void note_request(req_t r);
      res_t        e;
      int unsigned cap;
      int unsigned len;
      bit          done;
      e        = '0;
      e.status = ST_OK;
      cap      = r.buffer_capacity;
      case (r.req_type)
        REQ_ARM: begin
          if (cap == 0) begin
            stop_listening();
            e.status = ST_STOPPED;
          end else if (!listening) begin
            if (cap > MaxBuffer) cap = MaxBuffer;
            listening   = 1'b1;
            capacity    = CountW'(cap);
            byte_count  = '0;
            match_count = '0;
          end
        end
        REQ_STOP: begin
          stop_listening();
          e.status = ST_STOPPED;
        end
        REQ_BYTE: begin
          if (!listening) begin
            e.status = ST_IGNORED;
          end else begin
            len            = active_len();
            done           = 1'b0;
            e.write_enable = 1'b1;
            e.write_index  = byte_count;
            e.write_data   = r.rx_byte;
            if (r.rx_byte == delim_at(match_count)) begin
              match_count = match_count + 1'b1;
              if (match_count >= len) begin
                e.packet_length = CountW'(int'(byte_count) + 1 - int'(len));
                e.status        = ST_DONE;
                listening       = 1'b0;
                byte_count      = '0;
                capacity        = '0;
                match_count     = '0;
                done            = 1'b1;
              end
            end else begin
              // partial match broken: restart, possibly on this very byte
              match_count = (r.rx_byte == delim_at(0)) ? MatchW'(1) : '0;
            end
            if (!done) begin
              byte_count = byte_count + 1'b1;
              if (byte_count > capacity) begin
                listening = 1'b0;
                e.status  = ST_OVERFLOW;
              end
            end
          end
        end
        default: ;
      endcase
      pending_results.push_back(e);
    endfunction

    function void compare_field(string field, int unsigned want, int unsigned got);
      if (want != got) begin
        fail_count++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      end
    endfunction

    function void check_result(res_t got);
      res_t want;
      if (pending_results.size() == 0) begin
        fail_count++;
        $display("%0t: unexpected result, expected none, actual status %0d", $time, got.status);
        return;
      end
      want = pending_results.pop_front();
      compare_field("status", want.status, got.status);
      compare_field("packet_length", want.packet_length, got.packet_length);
      compare_field("write_enable", want.write_enable, got.write_enable);
      compare_field("write_index", want.write_index, got.write_index);
      compare_field("write_data", want.write_data, got.write_data);
    endfunction
  endclass

  logic                clk;
  logic                rst_n;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_index;
  logic [CfgDataW-1:0] cfg_data;
  bit                  steady_flow;
  int unsigned         counted;

  dpr_in_if  in_ch();
  dpr_out_if out_ch();

  deframer_tracker tracker = new();

  delimited_packet_receiver uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_req   (in_ch),
    .out_res  (out_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("Some tests failed");
    $finish;
  end

  // result side back-pressure
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      out_ch.ready <= steady_flow || ($urandom_range(0, 99) >= 37);
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        tracker.note_request(req_t'{in_ch.req_type, in_ch.rx_byte, in_ch.buffer_capacity});
      end
      if (out_ch.valid && out_ch.ready) begin
        tracker.check_result(res_t'{status_t'(out_ch.status), out_ch.packet_length,
                                    out_ch.write_enable, out_ch.write_index,
                                    out_ch.write_data});
      end
    end
  end

  // Offer one request, with an occasional gap first; returns once it is taken.
  task automatic push_request(input logic [ReqW-1:0] kind, input logic [ByteW-1:0] data,
                              input logic [CountW-1:0] cap);
    if (!steady_flow && $urandom_range(0, 99) < 37) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_ch.valid           <= 1'b1;
    in_ch.req_type        <= kind;
    in_ch.rx_byte         <= data;
    in_ch.buffer_capacity <= cap;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // Hold off requests until every result is back, then let the pipeline empty.
  task automatic settle();
    in_ch.valid <= 1'b0;
    // the request taken at this edge is noted by the monitor before the next one
    @(posedge clk);
    while (tracker.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_index_t idx, input logic [CfgDataW-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    tracker.write_reg(idx, value);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic byte_req(input logic [ByteW-1:0] data);
    push_request(REQ_BYTE, data, CountW'($urandom));
  endtask

  task automatic run_directed();
    byte_req(8'h00);                        // byte while idle
    push_request(REQ_STOP, 8'hFF, 9'h1FF);
    push_request(REQ_NONE, 8'hA5, 9'h100);
    push_request(REQ_ARM, 8'h00, 9'd0);     // zero capacity stops
    push_request(REQ_ARM, 8'h00, 9'd4);
    push_request(REQ_ARM, 8'h00, 9'd10);    // rejected while listening
    byte_req(8'h0D);
    byte_req(8'h0D);                        // mismatch on second delimiter byte, match restarts
    byte_req(8'h0A);
    push_request(REQ_ARM, 8'h00, 9'h1FF);   // saturates to max buffer
    byte_req(8'hFF);
    byte_req(8'h0D);
    byte_req(8'h0A);
    push_request(REQ_ARM, 8'h00, 9'd1);
    byte_req(8'h00);
    byte_req(8'h55);                        // index equals capacity: written, then overflow
    byte_req(8'h0D);
    // shrink the delimiter while a partial match is held
    push_request(REQ_ARM, 8'h00, 9'd20);
    byte_req(8'h0D);
    settle();
    write_reg(CFG_DELIM_LEN, CfgDataW'(1));
    byte_req(8'h0A);
    settle();
    write_reg(CFG_DELIM_LEN, CfgDataW'(DelimLenReset));
  endtask

  task automatic random_packet();
    int unsigned   pick;
    int unsigned   n;
    logic [CountW-1:0] cap;
    bit            plain;
    plain = 1'b0;
    pick  = $urandom_range(0, 99);
    if (pick < 4) begin
      // fill the whole buffer and run past it
      cap   = CountW'(MaxBuffer);
      n     = MaxBuffer + 4;
      plain = 1'b1;
    end else begin
      if (pick < 70) cap = CountW'($urandom_range(1, 48));
      else if (pick < 80) cap = CountW'(MaxBuffer);
      else if (pick < 90) cap = CountW'($urandom_range(MaxBuffer + 1, 511));
      else cap = CountW'($urandom_range(1, 6));
      n = $urandom_range(0, 30);
    end
    push_request(REQ_ARM, ByteW'($urandom), cap);
    counted++;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(0, 99);
      if (plain) begin
        byte_req(ByteW'($urandom));
      end else if (pick < 2) begin
        push_request(REQ_STOP, ByteW'($urandom), CountW'($urandom));
      end else if (pick < 4) begin
        push_request(REQ_ARM, ByteW'($urandom),
                     ($urandom_range(0, 3) == 0) ? '0 : CountW'($urandom));
      end else if (pick < 5) begin
        push_request(REQ_NONE, ByteW'($urandom), CountW'($urandom));
      end else if (pick < 50) begin
        byte_req(tracker.delim_at($urandom_range(0, tracker.active_len() - 1)));
      end else begin
        byte_req(ByteW'($urandom));
      end
      counted++;
    end
    if ($urandom_range(0, 99) < 85) begin
      for (int i = 0; i < tracker.active_len(); i++) begin
        byte_req(tracker.delim_at(i));
        counted++;
      end
    end
    // stray bytes between packets, mostly while idle
    if ($urandom_range(0, 99) < 10) begin
      repeat ($urandom_range(1, 3)) byte_req(ByteW'($urandom));
    end
  endtask

  initial begin
    logic [DelimW-1:0]    delim_set [NumPhases];
    logic [DelimLenW-1:0] len_set   [NumPhases];
    delim_set[0] = DelimBytesReset;             len_set[0] = DelimLenReset;
    delim_set[1] = '0;                          len_set[1] = 4'd1;
    delim_set[2] = '1;                          len_set[2] = 4'd8;
    delim_set[3] = {$urandom, $urandom};        len_set[3] = 4'd0;
    delim_set[4] = {$urandom, $urandom};        len_set[4] = 4'd15;
    delim_set[5] = 64'h0000_0000_0042_4141;     len_set[5] = 4'd3;
    delim_set[6] = {$urandom, $urandom};        len_set[6] = DelimLenW'($urandom_range(1, 8));
    delim_set[7] = DelimBytesReset;             len_set[7] = DelimLenReset;

    steady_flow           = 1'b0;
    counted               = 0;
    rst_n                 <= 1'b0;
    cfg_we                <= 1'b0;
    cfg_index             <= CFG_DELIM_BYTES;
    cfg_data              <= '0;
    in_ch.valid           <= 1'b0;
    in_ch.req_type        <= REQ_ARM;
    in_ch.rx_byte         <= '0;
    in_ch.buffer_capacity <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    run_directed();

    for (int p = 0; p < NumPhases; p++) begin
      settle();
      write_reg(CFG_DELIM_BYTES, delim_set[p]);
      write_reg(CFG_DELIM_LEN, CfgDataW'(len_set[p]));
      steady_flow = (p == 2);
      counted     = 0;
      while (counted < PhaseItems) random_packet();
    end
    steady_flow = 1'b0;

    settle();
    if (tracker.fail_count == 0 && tracker.pending() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

@@ delimited_packet_receiver.f @@
sv/dpr_pkg.sv
sv/dpr_in_if.sv
sv/dpr_out_if.sv
sv/dpr_core.sv
sv/delimited_packet_receiver.sv
tb/delimited_packet_receiver_tb.sv
